>>> rtl/core/sgi_pkg.sv
// Shared types and constants of the 2D segment intersection core.
`timescale 1ns / 1ps
package sgi_pkg;

  localparam int unsigned TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;
  localparam logic [2*TOL_W-1:0] TOL_SQ_RESET = 32'd429025;

  // Register stages of one on-segment test and steps of the quotient unit
  localparam int unsigned ONSEG_DEPTH = 7;
  localparam int unsigned DIV_STEPS = 32;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t a_origin_x;
    coord_t a_origin_y;
    coord_t a_dir_x;
    coord_t a_dir_y;
    coord_t b_origin_x;
    coord_t b_origin_y;
    coord_t b_dir_x;
    coord_t b_dir_y;
  } seg_pair_t;

  typedef struct packed {
    logic   hit;
    coord_t point_x;
    coord_t point_y;
  } hit_point_t;

endpackage

>>> rtl/core/sgi_if.sv
// Valid/ready channel carrying one word of type T.
`timescale 1ns / 1ps
interface sgi_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sgi_dly.sv
// Stallable delay line of N register stages for W bits of payload.
`timescale 1ns / 1ps
module sgi_dly #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  logic         clk_i,
  input  logic [N-1:0] en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] stage_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      stage_q[0] <= d_i;
    end
    for (int k = 1; k < int'(N); k++) begin
      if (en_i[k]) begin
        stage_q[k] <= stage_q[k-1];
      end
    end
  end

  assign q_o = stage_q[N-1];

endmodule

>>> rtl/core/sgi_onseg.sv
// Pipelined test of whether a point lies on a segment within the line tolerance.
`timescale 1ns / 1ps
module sgi_onseg import sgi_pkg::*; (
  input  logic                    clk_i,
  input  logic [ONSEG_DEPTH-1:0]  en_i,
  input  logic signed [32:0]      px_i,
  input  logic signed [32:0]      py_i,
  input  coord_t                  ox_i,
  input  coord_t                  oy_i,
  input  coord_t                  dx_i,
  input  coord_t                  dy_i,
  input  logic [2*TOL_W-1:0]      tol_sq_i,
  output logic                    pass_o
);

  // stage 1: offset from origin
  logic signed [33:0] rx_q, ry_q;
  coord_t dx1_q, dy1_q;
  // stage 2: products
  logic signed [67:0] rxx_q, ryy_q;
  logic signed [63:0] dxx_q, dyy_q;
  logic signed [65:0] rxdx_q, rydy_q, dxry_q, dyrx_q;
  // stage 3: sums
  logic [67:0] rr_q;
  logic [63:0] dd3_q;
  logic signed [66:0] dot_q, cr_q;
  // stage 4: magnitude and early checks
  logic [66:0] m_abs;
  logic [47:0] m_q;
  logic [63:0] dd4_q;
  logic ok4_q;
  // stage 5: partial products
  logic [71:0] sqh_q, sql_q;
  logic [63:0] limh_q, liml_q;
  logic ok5_q;
  // stage 6: squared distance against the bound
  logic [95:0] sq_q, lim_q;
  logic ok6_q;
  logic pass_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rx_q  <= 34'(px_i) - 34'(ox_i);
      ry_q  <= 34'(py_i) - 34'(oy_i);
      dx1_q <= dx_i;
      dy1_q <= dy_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rxx_q  <= rx_q * rx_q;
      ryy_q  <= ry_q * ry_q;
      dxx_q  <= dx1_q * dx1_q;
      dyy_q  <= dy1_q * dy1_q;
      rxdx_q <= rx_q * dx1_q;
      rydy_q <= ry_q * dy1_q;
      dxry_q <= dx1_q * ry_q;
      dyrx_q <= dy1_q * rx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      rr_q  <= $unsigned(rxx_q) + $unsigned(ryy_q);
      dd3_q <= $unsigned(dxx_q) + $unsigned(dyy_q);
      dot_q <= 67'(rxdx_q) + 67'(rydy_q);
      cr_q  <= 67'(dxry_q) - 67'(dyrx_q);
    end
  end

  assign m_abs = cr_q[66] ? (~$unsigned(cr_q) + 67'd1) : $unsigned(cr_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      m_q   <= m_abs[47:0];
      dd4_q <= dd3_q;
      // within length, ahead of the origin, and cross small enough to square
      ok4_q <= (rr_q <= {4'b0, dd3_q}) && !dot_q[66] && (m_abs[66:48] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      sqh_q  <= m_q[47:24] * m_q;
      sql_q  <= m_q[23:0] * m_q;
      limh_q <= tol_sq_i * dd4_q[63:32];
      liml_q <= tol_sq_i * dd4_q[31:0];
      ok5_q  <= ok4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      sq_q  <= {sqh_q, 24'b0} + {24'b0, sql_q};
      lim_q <= {limh_q, 32'b0} + {32'b0, liml_q};
      ok6_q <= ok5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      pass_q <= ok6_q && (sq_q <= lim_q);
    end
  end

  assign pass_o = pass_q;

endmodule

>>> rtl/core/sgi_div.sv
// Pipelined restoring divider, one quotient bit per stage, 32-bit quotient.
`timescale 1ns / 1ps
module sgi_div import sgi_pkg::*; (
  input  logic                 clk_i,
  input  logic [DIV_STEPS-1:0] en_i,
  input  logic [95:0]          num_i,
  input  logic [63:0]          den_i,
  output logic [31:0]          quo_o
);

  logic [63:0] rem_q [DIV_STEPS];
  logic [31:0] low_q [DIV_STEPS];
  logic [63:0] den_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [63:0] rem_in;
    logic [31:0] low_in;
    logic [63:0] den_in;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in = num_i[95:32];
      assign low_in = num_i[31:0];
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign low_in = low_q[j-1];
      assign den_in = den_q[j-1];
    end

    // bring down the next dividend bit, subtract when the divisor fits
    assign trial = {rem_in, low_in[31]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= ge ? diff[63:0] : trial[63:0];
        low_q[j] <= {low_in[30:0], ge};
        den_q[j] <= den_in;
      end
    end
  end

  assign quo_o = low_q[DIV_STEPS-1];

endmodule

>>> rtl/core/segment_intersection_2d_core.sv
// Top level of the pipelined 2D segment intersection core.
//
// Use: present two segments (origin and direction each, signed Q16.16) as one
// word on in_if; one word per input comes back on out_if with a hit flag and
// the meeting point (zero when there is no hit). Both channels are valid/ready
// and a word moves on a rising edge where both are high.
// Throughput: one word per cycle while out_if takes its words. The time from
// acceptance to valid at out_if is set by the 32 quotient stages of the
// divider that places the crossing point plus one on-segment test pipeline
// (7 stages; the two run side by side) and a few stages of products and sums.
// Stall: every stage advances while any stage at or after it holds a bubble
// or out_if is taking its word, so gaps close up and input keeps flowing
// until the whole pipe is full; nothing is dropped or repeated.
// Reset: clears all valid bits and loads the line tolerance with 655 (about
// 0.01). Write the tolerance through cfg_we_i / cfg_wdata_i only while the
// core holds no word in flight.
`timescale 1ns / 1ps
module segment_intersection_2d_core import sgi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  sgi_if.sink              in_if,
  sgi_if.source            out_if,
  input  logic             cfg_we_i,
  input  logic [TOL_W-1:0] cfg_wdata_i
);

  // Stage map
  localparam int unsigned ST_END  = 1;                       // end points, deltas
  localparam int unsigned ST_EP   = ST_END + ONSEG_DEPTH;    // end point tests done
  localparam int unsigned ST_PROD = 2;                       // cross products
  localparam int unsigned ST_DIFF = 3;                       // numerator, denominator
  localparam int unsigned ST_ABS  = 4;                       // magnitudes, far check
  localparam int unsigned ST_PART = 5;                       // dir * numerator partials
  localparam int unsigned ST_NUM  = 6;                       // dividends
  localparam int unsigned ST_QUO  = ST_NUM + DIV_STEPS;      // quotients out
  localparam int unsigned ST_PT   = ST_QUO + 1;              // crossing point
  localparam int unsigned ST_FIN  = ST_PT + ONSEG_DEPTH;     // crossing tests done
  localparam int unsigned ST_OUT  = ST_FIN + 1;              // output register
  localparam int unsigned NSTAGES = ST_OUT + 1;

  typedef struct packed {
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t a_end_x;
    coord_t a_end_y;
  } ends_t;

  typedef struct packed {
    seg_pair_t seg;
    ends_t     ends;
  } carry_t;

  typedef struct packed {
    carry_t c;
    coord_t px;
    coord_t py;
  } pts_t;

  typedef struct packed {
    logic num_neg;
    logic den_neg;
  } sign_t;

  typedef struct packed {
    logic den_zero;
    logic far;
  } miss_t;

  // ---------------------------------------------------------------------------
  // Flow control: valid bit per stage, stage k loads when any stage from k on
  // is empty or the output word is being taken.
  // ---------------------------------------------------------------------------
  logic [NSTAGES-1:0] v_q;
  logic [NSTAGES-1:0] en;

  for (genvar k = 0; k < NSTAGES; k++) begin : g_en
    assign en[k] = out_if.ready || !(&v_q[NSTAGES-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_if.valid;
      end
      for (int k = 1; k < int'(NSTAGES); k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_if.ready = en[0];

  // Tolerance is only ever used squared: hold the square.
  logic [2*TOL_W-1:0] tol_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_sq_q <= TOL_SQ_RESET;
    end else if (cfg_we_i) begin
      tol_sq_q <= 32'(cfg_wdata_i) * 32'(cfg_wdata_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Input register, then end points and origin deltas
  // ---------------------------------------------------------------------------
  seg_pair_t s0_q, s1_q;
  logic signed [32:0] bex1_q, bey1_q, aex1_q, aey1_q, dfx1_q, dfy1_q;
  logic [31:0] magx1_q, magy1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q <= in_if.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_END]) begin
      s1_q    <= s0_q;
      bex1_q  <= 33'(s0_q.b_origin_x) + 33'(s0_q.b_dir_x);
      bey1_q  <= 33'(s0_q.b_origin_y) + 33'(s0_q.b_dir_y);
      aex1_q  <= 33'(s0_q.a_origin_x) + 33'(s0_q.a_dir_x);
      aey1_q  <= 33'(s0_q.a_origin_y) + 33'(s0_q.a_dir_y);
      dfx1_q  <= 33'(s0_q.b_origin_x) - 33'(s0_q.a_origin_x);
      dfy1_q  <= 33'(s0_q.b_origin_y) - 33'(s0_q.a_origin_y);
      magx1_q <= s0_q.a_dir_x[31] ? (~$unsigned(s0_q.a_dir_x) + 32'd1)
                                  : $unsigned(s0_q.a_dir_x);
      magy1_q <= s0_q.a_dir_y[31] ? (~$unsigned(s0_q.a_dir_y) + 32'd1)
                                  : $unsigned(s0_q.a_dir_y);
    end
  end

  // ---------------------------------------------------------------------------
  // End point tests, in precedence order: B origin, B end on A; A origin,
  // A end on B.
  // ---------------------------------------------------------------------------
  logic [3:0] ep8;

  sgi_onseg u_ep_bo (
    .clk_i, .en_i(en[ST_EP:ST_END+1]),
    .px_i(33'(s1_q.b_origin_x)), .py_i(33'(s1_q.b_origin_y)),
    .ox_i(s1_q.a_origin_x), .oy_i(s1_q.a_origin_y),
    .dx_i(s1_q.a_dir_x), .dy_i(s1_q.a_dir_y),
    .tol_sq_i(tol_sq_q), .pass_o(ep8[0])
  );

  sgi_onseg u_ep_be (
    .clk_i, .en_i(en[ST_EP:ST_END+1]),
    .px_i(bex1_q), .py_i(bey1_q),
    .ox_i(s1_q.a_origin_x), .oy_i(s1_q.a_origin_y),
    .dx_i(s1_q.a_dir_x), .dy_i(s1_q.a_dir_y),
    .tol_sq_i(tol_sq_q), .pass_o(ep8[1])
  );

  sgi_onseg u_ep_ao (
    .clk_i, .en_i(en[ST_EP:ST_END+1]),
    .px_i(33'(s1_q.a_origin_x)), .py_i(33'(s1_q.a_origin_y)),
    .ox_i(s1_q.b_origin_x), .oy_i(s1_q.b_origin_y),
    .dx_i(s1_q.b_dir_x), .dy_i(s1_q.b_dir_y),
    .tol_sq_i(tol_sq_q), .pass_o(ep8[2])
  );

  sgi_onseg u_ep_ae (
    .clk_i, .en_i(en[ST_EP:ST_END+1]),
    .px_i(aex1_q), .py_i(aey1_q),
    .ox_i(s1_q.b_origin_x), .oy_i(s1_q.b_origin_y),
    .dx_i(s1_q.b_dir_x), .dy_i(s1_q.b_dir_y),
    .tol_sq_i(tol_sq_q), .pass_o(ep8[3])
  );

  // ---------------------------------------------------------------------------
  // Cramer's rule: den = cross(Da, Db), num = cross(Ob - Oa, Db)
  // ---------------------------------------------------------------------------
  logic signed [63:0] pd1_q, pd2_q;
  logic signed [64:0] pn1_q, pn2_q;
  logic signed [64:0] den_q;
  logic signed [65:0] num_q;
  logic [64:0] aden;
  logic [65:0] anum;
  logic [63:0] aden4_q, anum4_q;
  sign_t sg4_q;
  miss_t ms4_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_PROD]) begin
      pd1_q <= s1_q.a_dir_x * s1_q.b_dir_y;
      pd2_q <= s1_q.a_dir_y * s1_q.b_dir_x;
      pn1_q <= dfx1_q * s1_q.b_dir_y;
      pn2_q <= dfy1_q * s1_q.b_dir_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_DIFF]) begin
      den_q <= 65'(pd1_q) - 65'(pd2_q);
      num_q <= 66'(pn1_q) - 66'(pn2_q);
    end
  end

  assign aden = den_q[64] ? (~$unsigned(den_q) + 65'd1) : $unsigned(den_q);
  assign anum = num_q[65] ? (~$unsigned(num_q) + 66'd1) : $unsigned(num_q);

  always_ff @(posedge clk_i) begin
    if (en[ST_ABS]) begin
      aden4_q        <= aden[63:0];
      anum4_q        <= anum[63:0];
      sg4_q.num_neg  <= num_q[65];
      sg4_q.den_neg  <= den_q[64];
      ms4_q.den_zero <= (den_q == '0);
      // a crossing farther from A's origin than A's length cannot pass the test on A
      ms4_q.far      <= (anum > {1'b0, aden});
    end
  end

  // |D| * |num|, split into 32 x 32 partial products
  logic [31:0] magx4, magy4;
  logic [63:0] pxh_q, pxl_q, pyh_q, pyl_q;
  logic [95:0] nx_q, ny_q;
  logic [63:0] aden6;

  sgi_dly #(.W(64), .N(ST_ABS - ST_END)) u_dly_mag (
    .clk_i, .en_i(en[ST_ABS:ST_END+1]),
    .d_i({magx1_q, magy1_q}), .q_o({magx4, magy4})
  );

  always_ff @(posedge clk_i) begin
    if (en[ST_PART]) begin
      pxh_q <= magx4 * anum4_q[63:32];
      pxl_q <= magx4 * anum4_q[31:0];
      pyh_q <= magy4 * anum4_q[63:32];
      pyl_q <= magy4 * anum4_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_NUM]) begin
      nx_q <= {pxh_q, 32'b0} + {32'b0, pxl_q};
      ny_q <= {pyh_q, 32'b0} + {32'b0, pyl_q};
    end
  end

  sgi_dly #(.W(64), .N(ST_NUM - ST_ABS)) u_dly_den (
    .clk_i, .en_i(en[ST_NUM:ST_ABS+1]), .d_i(aden4_q), .q_o(aden6)
  );

  // Offsets along A, rounded toward zero
  logic [31:0] qx, qy;

  sgi_div u_div_x (
    .clk_i, .en_i(en[ST_QUO:ST_NUM+1]), .num_i(nx_q), .den_i(aden6), .quo_o(qx)
  );

  sgi_div u_div_y (
    .clk_i, .en_i(en[ST_QUO:ST_NUM+1]), .num_i(ny_q), .den_i(aden6), .quo_o(qy)
  );

  // Hold operands and signs alongside the divider
  carry_t c1, c38;
  sign_t sg38;

  assign c1.seg          = s1_q;
  assign c1.ends.b_end_x = bex1_q[31:0];
  assign c1.ends.b_end_y = bey1_q[31:0];
  assign c1.ends.a_end_x = aex1_q[31:0];
  assign c1.ends.a_end_y = aey1_q[31:0];

  sgi_dly #(.W($bits(carry_t)), .N(ST_QUO - ST_END)) u_dly_carry (
    .clk_i, .en_i(en[ST_QUO:ST_END+1]), .d_i(c1), .q_o(c38)
  );

  sgi_dly #(.W($bits(sign_t)), .N(ST_QUO - ST_ABS)) u_dly_sign (
    .clk_i, .en_i(en[ST_QUO:ST_ABS+1]), .d_i(sg4_q), .q_o(sg38)
  );

  // ---------------------------------------------------------------------------
  // Crossing point P = Oa + signed offset
  // ---------------------------------------------------------------------------
  logic negx, negy;
  logic signed [32:0] offx, offy;
  logic signed [32:0] px39_q, py39_q;
  carry_t c39_q;

  assign negx = c38.seg.a_dir_x[31] ^ sg38.num_neg ^ sg38.den_neg;
  assign negy = c38.seg.a_dir_y[31] ^ sg38.num_neg ^ sg38.den_neg;
  assign offx = negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
  assign offy = negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

  always_ff @(posedge clk_i) begin
    if (en[ST_PT]) begin
      px39_q <= 33'(c38.seg.a_origin_x) + offx;
      py39_q <= 33'(c38.seg.a_origin_y) + offy;
      c39_q  <= c38;
    end
  end

  logic fin_a, fin_b;

  sgi_onseg u_fin_a (
    .clk_i, .en_i(en[ST_FIN:ST_PT+1]),
    .px_i(px39_q), .py_i(py39_q),
    .ox_i(c39_q.seg.a_origin_x), .oy_i(c39_q.seg.a_origin_y),
    .dx_i(c39_q.seg.a_dir_x), .dy_i(c39_q.seg.a_dir_y),
    .tol_sq_i(tol_sq_q), .pass_o(fin_a)
  );

  sgi_onseg u_fin_b (
    .clk_i, .en_i(en[ST_FIN:ST_PT+1]),
    .px_i(px39_q), .py_i(py39_q),
    .ox_i(c39_q.seg.b_origin_x), .oy_i(c39_q.seg.b_origin_y),
    .dx_i(c39_q.seg.b_dir_x), .dy_i(c39_q.seg.b_dir_y),
    .tol_sq_i(tol_sq_q), .pass_o(fin_b)
  );

  // Candidate points and flags, aligned to the last test stage
  pts_t p39, p46;
  logic [3:0] ep46;
  miss_t ms46;

  assign p39.c  = c39_q;
  assign p39.px = px39_q[31:0];
  assign p39.py = py39_q[31:0];

  sgi_dly #(.W($bits(pts_t)), .N(ST_FIN - ST_PT)) u_dly_pts (
    .clk_i, .en_i(en[ST_FIN:ST_PT+1]), .d_i(p39), .q_o(p46)
  );

  sgi_dly #(.W(4), .N(ST_FIN - ST_EP)) u_dly_ep (
    .clk_i, .en_i(en[ST_FIN:ST_EP+1]), .d_i(ep8), .q_o(ep46)
  );

  sgi_dly #(.W($bits(miss_t)), .N(ST_FIN - ST_ABS)) u_dly_miss (
    .clk_i, .en_i(en[ST_FIN:ST_ABS+1]), .d_i(ms4_q), .q_o(ms46)
  );

  // ---------------------------------------------------------------------------
  // Result select by precedence, into the output register
  // ---------------------------------------------------------------------------
  hit_point_t out_d, out_q;

  always_comb begin
    out_d = '0;
    if (ep46[0]) begin
      out_d.hit     = 1'b1;
      out_d.point_x = p46.c.seg.b_origin_x;
      out_d.point_y = p46.c.seg.b_origin_y;
    end else if (ep46[1]) begin
      out_d.hit     = 1'b1;
      out_d.point_x = p46.c.ends.b_end_x;
      out_d.point_y = p46.c.ends.b_end_y;
    end else if (ep46[2]) begin
      out_d.hit     = 1'b1;
      out_d.point_x = p46.c.seg.a_origin_x;
      out_d.point_y = p46.c.seg.a_origin_y;
    end else if (ep46[3]) begin
      out_d.hit     = 1'b1;
      out_d.point_x = p46.c.ends.a_end_x;
      out_d.point_y = p46.c.ends.a_end_y;
    end else if (!ms46.den_zero && !ms46.far && fin_a && fin_b) begin
      out_d.hit     = 1'b1;
      out_d.point_x = p46.px;
      out_d.point_y = p46.py;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      out_q <= out_d;
    end
  end

  assign out_if.valid = v_q[NSTAGES-1];
  assign out_if.data  = out_q;

endmodule
